// ----- rtl/radio_synced_clock_controller_defines.svh -----
// Assertion macros used by the checker file of the radio synced clock controller.
`ifndef RADIO_SYNCED_CLOCK_CONTROLLER_DEFINES_SVH
`define RADIO_SYNCED_CLOCK_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSCC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSCC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rscc_pkg.sv -----
// Package with the shared types, constants and digit helpers of the clock controller.
`default_nettype none
package rscc_pkg;

  localparam int unsigned POINT_POSITIONS = 8;
  localparam int unsigned POINT_W = $clog2(POINT_POSITIONS);

  localparam logic [2:0] MODE_SETUP  = 3'd0;
  localparam logic [2:0] MODE_SEARCH = 3'd1;
  localparam logic [2:0] MODE_RUN    = 3'd2;
  localparam logic [2:0] MODE_RESYNC = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  localparam logic REG_IDX_ONE_SECOND = 1'b0;
  localparam logic REG_IDX_RESYNC     = 1'b1;

  localparam logic [31:0] ONE_SECOND_RESET = 32'd1000000;
  localparam logic [39:0] RESYNC_RESET     = 40'd18000000000;

  typedef struct packed {
    logic [31:0] one_second_us;
    logic [39:0] resync_period_us;
  } cfg_t;

  // Tens digit of a value below 64.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  // Ones digit of a value below 64.
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(tens_of(v)) * 6'd10;
    return r[3:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rscc_regs.sv -----
// Configuration register file of the clock controller behind an APB-style port.
`default_nettype none
module rscc_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [63:0]   pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output rscc_pkg::cfg_t     cfg
);

  logic wr_en;

  // Registers sit eight bytes apart, so only address bit three selects one.
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_second_us    <= rscc_pkg::ONE_SECOND_RESET;
      cfg.resync_period_us <= rscc_pkg::RESYNC_RESET;
    end else if (wr_en) begin
      if (paddr[3] == rscc_pkg::REG_IDX_ONE_SECOND) begin
        cfg.one_second_us <= pwdata[31:0];
      end else begin
        cfg.resync_period_us <= pwdata[39:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == rscc_pkg::REG_IDX_RESYNC) begin
      prdata = {24'd0, cfg.resync_period_us};
    end else begin
      prdata = {32'd0, cfg.one_second_us};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/radio_synced_clock_controller.sv -----
// Top level of the radio synced clock controller: input stage, mode logic and result register.
// Usage notes:
// Each input transfer is one controller call carrying the microsecond time, the radio
// decoder flags and decoded time, and the real-time clock reading. Each call yields
// exactly one result transfer with the tube digits, dot position, power enables,
// controller mode and the clock-write strobe with its hours and minutes.
// An accepted call is held in an input register; the mode logic then updates the
// controller state and loads the result register once that register is free or
// being read. One call is accepted every cycle while the receiver takes results; the
// rate is set by the combinational state update (one 64-bit subtract and two compares).
// When the receiver stalls, the result register holds its value and one more call can
// still be taken into the input register; after that in_ready drops until out_ready.
// Reset clears the mode to setup, the time mark and dot position to zero, darkens the
// tubes and dots, empties both stages and loads the interval registers with their
// default values. The interval registers are written over the APB-style port; the user
// writes them only while no call is in flight, and the block itself does not enforce this.
`default_nettype none
module radio_synced_clock_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] now_us,
  input  wire logic        dcf_time_valid,
  input  wire logic        dcf_signal_timeout,
  input  wire logic [4:0]  dcf_hours,
  input  wire logic [5:0]  dcf_minutes,
  input  wire logic [4:0]  rtc_hours,
  input  wire logic [5:0]  rtc_minutes,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       hours_tens,
  output logic [3:0]       hours_ones,
  output logic [3:0]       minutes_tens,
  output logic [3:0]       minutes_ones,
  output logic             tubes_on,
  output logic [2:0]       points_index,
  output logic             points_on,
  output logic [2:0]       controller_mode,
  output logic             rtc_write,
  output logic [4:0]       rtc_write_hours,
  output logic [5:0]       rtc_write_minutes
);

  localparam int unsigned PW = rscc_pkg::POINT_W;

  rscc_pkg::cfg_t cfg;

  rscc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage.
  logic        s1_valid;
  logic [63:0] s1_now;
  logic        s1_tvalid;
  logic        s1_timeout;
  logic [4:0]  s1_dh;
  logic [5:0]  s1_dm;
  logic [4:0]  s1_rh;
  logic [5:0]  s1_rm;
  logic        advance;

  // Controller state.
  logic [2:0]    mode, mode_next;
  logic [63:0]   mark, mark_next;
  logic [3:0]    digits [4];
  logic [3:0]    digits_next [4];
  logic [PW-1:0] point, point_next;
  logic          tubes, tubes_next;
  logic          points, points_next;
  logic          wr_next;
  logic [4:0]    wr_hours_next;
  logic [5:0]    wr_minutes_next;

  logic [63:0]   elapsed;
  logic          second_passed;
  logic          resync_passed;
  logic [PW-1:0] point_step;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now     <= now_us;
      s1_tvalid  <= dcf_time_valid;
      s1_timeout <= dcf_signal_timeout;
      s1_dh      <= dcf_hours;
      s1_dm      <= dcf_minutes;
      s1_rh      <= rtc_hours;
      s1_rm      <= rtc_minutes;
    end
  end

  // Wrapping difference against the stored mark; zero-extended limits.
  assign elapsed       = s1_now - mark;
  assign second_passed = elapsed > {32'd0, cfg.one_second_us};
  assign resync_passed = elapsed > {24'd0, cfg.resync_period_us};
  assign point_step    = (point == PW'(rscc_pkg::POINT_POSITIONS - 1)) ? '0 : point + 1'b1;

  always_comb begin
    mode_next       = mode;
    mark_next       = mark;
    digits_next     = digits;
    point_next      = point;
    tubes_next      = tubes;
    points_next     = points;
    wr_next         = 1'b0;
    wr_hours_next   = '0;
    wr_minutes_next = '0;

    case (mode)
      rscc_pkg::MODE_SETUP: begin
        mode_next = rscc_pkg::MODE_SEARCH;
      end
      rscc_pkg::MODE_SEARCH: begin
        if (second_passed) begin
          mark_next  = s1_now;
          point_next = point_step;
        end
        if (s1_tvalid) begin
          mode_next = rscc_pkg::MODE_RUN;
        end else if (s1_timeout) begin
          mode_next = rscc_pkg::MODE_ERROR;
        end
      end
      rscc_pkg::MODE_RUN, rscc_pkg::MODE_RESYNC: begin
        digits_next[0] = rscc_pkg::tens_of({1'b0, s1_rh});
        digits_next[1] = rscc_pkg::ones_of({1'b0, s1_rh});
        digits_next[2] = rscc_pkg::tens_of(s1_rm);
        digits_next[3] = rscc_pkg::ones_of(s1_rm);
        if (resync_passed) begin
          mark_next = s1_now;
          mode_next = (mode == rscc_pkg::MODE_RUN) ? rscc_pkg::MODE_RESYNC
                                                   : rscc_pkg::MODE_SEARCH;
        end else if (mode == rscc_pkg::MODE_RESYNC && s1_tvalid) begin
          mode_next = rscc_pkg::MODE_RUN;
        end
      end
      rscc_pkg::MODE_ERROR: begin
        point_next = point_step;
        if (!s1_timeout) begin
          mode_next = rscc_pkg::MODE_SEARCH;
        end
      end
      default: begin
      end
    endcase

    // Entry actions apply only when the mode actually changes.
    if (mode_next != mode) begin
      case (mode_next)
        rscc_pkg::MODE_SEARCH, rscc_pkg::MODE_ERROR: begin
          mark_next   = '0;
          tubes_next  = 1'b0;
          points_next = 1'b1;
        end
        rscc_pkg::MODE_RUN: begin
          wr_next         = 1'b1;
          wr_hours_next   = s1_dh;
          wr_minutes_next = s1_dm;
          mark_next       = s1_now;
          tubes_next      = 1'b1;
          points_next     = 1'b0;
        end
        rscc_pkg::MODE_RESYNC: begin
          mark_next = s1_now;
        end
        default: begin
        end
      endcase
    end
  end

  // Controller state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= rscc_pkg::MODE_SETUP;
      mark              <= '0;
      digits            <= '{default: 4'd0};
      point             <= '0;
      tubes             <= 1'b0;
      points            <= 1'b0;
      out_valid         <= 1'b0;
      hours_tens        <= '0;
      hours_ones        <= '0;
      minutes_tens      <= '0;
      minutes_ones      <= '0;
      tubes_on          <= 1'b0;
      points_index      <= '0;
      points_on         <= 1'b0;
      controller_mode   <= rscc_pkg::MODE_SETUP;
      rtc_write         <= 1'b0;
      rtc_write_hours   <= '0;
      rtc_write_minutes <= '0;
    end else if (advance) begin
      mode              <= mode_next;
      mark              <= mark_next;
      digits            <= digits_next;
      point             <= point_next;
      tubes             <= tubes_next;
      points            <= points_next;
      out_valid         <= 1'b1;
      hours_tens        <= digits_next[0];
      hours_ones        <= digits_next[1];
      minutes_tens      <= digits_next[2];
      minutes_ones      <= digits_next[3];
      tubes_on          <= tubes_next;
      points_index      <= 3'(point_next);
      points_on         <= points_next;
      controller_mode   <= mode_next;
      rtc_write         <= wr_next;
      rtc_write_hours   <= wr_hours_next;
      rtc_write_minutes <= wr_minutes_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rscc_checker.sv -----
// Port-level checker of the clock controller and its bind to the top level.
`default_nettype none
`include "radio_synced_clock_controller_defines.svh"
module rscc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       tubes_on,
  input wire logic       points_on,
  input wire logic [2:0] controller_mode,
  input wire logic       rtc_write,
  input wire logic [4:0] rtc_write_hours,
  input wire logic [5:0] rtc_write_minutes
);

  `RSCC_ASSERT_SAME(a_write_enters_run, out_valid && rtc_write, controller_mode == rscc_pkg::MODE_RUN && tubes_on && !points_on, "clock write without entry into running mode")

  `RSCC_ASSERT_SAME(a_search_display, out_valid && (controller_mode == rscc_pkg::MODE_SEARCH || controller_mode == rscc_pkg::MODE_ERROR), !tubes_on && points_on, "search or error mode with wrong tube power")

  `RSCC_ASSERT_SAME(a_run_display, out_valid && (controller_mode == rscc_pkg::MODE_RUN || controller_mode == rscc_pkg::MODE_RESYNC), tubes_on && !points_on, "running or resync mode with wrong tube power")

  `RSCC_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(controller_mode) && $stable(rtc_write) && $stable(rtc_write_hours) && $stable(rtc_write_minutes), "stalled result changed")

endmodule

bind radio_synced_clock_controller rscc_checker u_rscc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .tubes_on          (tubes_on),
  .points_on         (points_on),
  .controller_mode   (controller_mode),
  .rtc_write         (rtc_write),
  .rtc_write_hours   (rtc_write_hours),
  .rtc_write_minutes (rtc_write_minutes)
);
`default_nettype wire
